// ----- src/sgc_pkg.sv -----
// shared constants and types of the signed elias gamma codec
package sgc_pkg;

    // width of the signed values that are encoded
    localparam int VALUE_BITS = 28;
    // width of the mapped value and of the decoded value
    localparam int M_BITS = VALUE_BITS + 1;
    // counter width: holds 0 .. M_BITS
    localparam int CNT_BITS = $clog2(M_BITS + 1);
    localparam int KIND_BITS = 2;

    typedef logic [KIND_BITS-1:0] kind_t;

    localparam kind_t KIND_BIT   = kind_t'(0);
    localparam kind_t KIND_VALUE = kind_t'(1);
    localparam kind_t KIND_ERROR = kind_t'(2);

endpackage

// ----- src/sgc_if.sv -----
// channel interfaces of the signed elias gamma codec

interface sgc_item_if;
    logic                                valid;
    logic                                ready;
    logic signed [sgc_pkg::VALUE_BITS-1:0] signed_value;
    logic                                code_bit;
    logic                                end_of_stream;

    modport source (output valid, output signed_value, output code_bit,
                    output end_of_stream, input ready);
    modport sink   (input valid, input signed_value, input code_bit,
                    input end_of_stream, output ready);
endinterface

interface sgc_result_if;
    logic                              valid;
    logic                              ready;
    sgc_pkg::kind_t                    result_kind;
    logic                              out_bit;
    logic signed [sgc_pkg::M_BITS-1:0] decoded_value;
    logic                              last_of_run;

    modport source (output valid, output result_kind, output out_bit,
                    output decoded_value, output last_of_run, input ready);
    modport sink   (input valid, input result_kind, input out_bit,
                    input decoded_value, input last_of_run, output ready);
endinterface

interface sgc_cfg_if;
    logic valid;
    logic ready;
    logic decode_mode;

    modport source (output valid, output decode_mode, input ready);
    modport sink   (input valid, input decode_mode, output ready);
endinterface

// ----- src/signed_elias_gamma_codec.sv -----
// top level of the signed elias gamma codec: bit-serial encoder and decoder
//
// Signed Elias gamma codec. With decode_mode at 0 each item carries a signed
// value; it is mapped (zero to 1, positive v to 2v+1, negative v to -2v) and
// sent as floor(log2 m) zero bits followed by the bits of m, msb first, one
// result per code bit; end_of_stream appends zero bits up to a byte boundary.
// An encode item is loaded, then its 29-bit mapped value is normalized in its
// shift register, one leading zero shifted out per step, and then its code
// bits and pad bits are sent, one result each: a code of 2n+1 bits plus up to
// 7 pad bits; the next item is taken once the last result has been loaded
// into the output register. With decode_mode at 1 each item carries one code
// bit; a bit that completes a value, or a zero run longer than the value
// width, gives one result, so the decoder takes one item per cycle as long as
// the output register drains. The mode register is to be written over the cfg
// channel only while the block is idle; the block does not enforce this, and
// a write does not clear the coder state.
module signed_elias_gamma_codec (
    input logic           clk,
    input logic           rst_n,
    sgc_item_if.sink      item,
    sgc_result_if.source  result,
    sgc_cfg_if.sink       cfg
);

    // encoder sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_NORM  = 3'd1;  // shift mapped value up to its msb
    localparam logic [2:0] ST_ZEROS = 3'd2;  // unary prefix of zero bits
    localparam logic [2:0] ST_BITS  = 3'd3;  // binary digits of the mapped value
    localparam logic [2:0] ST_PAD   = 3'd4;  // byte alignment padding

    localparam int MB = sgc_pkg::M_BITS;
    localparam int CB = sgc_pkg::CNT_BITS;

    logic [2:0]          state_reg, state_next;
    logic                mode_reg;

    // encoder datapath
    logic [MB-1:0]       m_reg, m_next;
    logic [CB-1:0]       nbits_reg, nbits_next;
    logic [CB-1:0]       cnt_reg, cnt_next;
    logic                eos_reg, eos_next;
    logic [2:0]          emod_reg, emod_next;

    // decoder state
    logic [CB-1:0]       zero_run_reg, zero_run_next;
    logic                reading_reg, reading_next;
    logic [MB-1:0]       pay_reg, pay_next;
    logic [CB-1:0]       pay_cnt_reg, pay_cnt_next;

    // output register
    logic                out_valid_reg;
    sgc_pkg::kind_t      out_kind_reg;
    logic                out_bit_reg;
    logic [MB-1:0]       out_val_reg;
    logic                out_last_reg;

    logic                can_emit;
    logic                item_take;
    logic                emit;
    sgc_pkg::kind_t      emit_kind;
    logic                emit_bit;
    logic [MB-1:0]       emit_val;
    logic                emit_last;

    // mapped value and decoder helpers
    logic [sgc_pkg::VALUE_BITS-1:0] raw;
    logic [sgc_pkg::VALUE_BITS-1:0] raw_neg;
    logic [MB-1:0]       m_in;
    logic [MB-1:0]       dec_pay;
    logic [CB-1:0]       dec_cnt;
    logic [MB-1:0]       dec_half;
    logic [MB-1:0]       dec_val;

    // output slot is free or drains in this cycle
    assign can_emit  = !out_valid_reg || result.ready;
    assign item.ready = (state_reg == ST_IDLE) && (!mode_reg || can_emit);
    assign item_take = item.valid && item.ready;
    assign cfg.ready = 1'b1;

    // zero maps to 1 since {0, 1} is 1
    assign raw     = item.signed_value;
    assign raw_neg = -raw;
    assign m_in    = raw[sgc_pkg::VALUE_BITS-1] ? {raw_neg, 1'b0} : {raw, 1'b1};

    // payload with the new bit; a leading one starts the payload
    assign dec_pay  = reading_reg ? {pay_reg[MB-2:0], item.code_bit} : MB'(1);
    assign dec_cnt  = reading_reg ? pay_cnt_reg + CB'(1) : CB'(1);
    // odd payload gives zero or a positive value, even gives negative
    assign dec_half = dec_pay >> 1;
    assign dec_val  = dec_pay[0] ? dec_half : -dec_half;

    always_comb
    begin
        state_next    = state_reg;
        m_next        = m_reg;
        nbits_next    = nbits_reg;
        cnt_next      = cnt_reg;
        eos_next      = eos_reg;
        emod_next     = emod_reg;
        zero_run_next = zero_run_reg;
        reading_next  = reading_reg;
        pay_next      = pay_reg;
        pay_cnt_next  = pay_cnt_reg;
        emit          = 1'b0;
        emit_kind     = sgc_pkg::KIND_BIT;
        emit_bit      = 1'b0;
        emit_val      = '0;
        emit_last     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_take)
                begin
                    if (mode_reg)
                    begin
                        if (!reading_reg && !item.code_bit)
                        begin
                            // still in the zero prefix
                            if (zero_run_reg >= CB'(sgc_pkg::VALUE_BITS))
                            begin
                                zero_run_next = '0;
                                emit          = 1'b1;
                                emit_kind     = sgc_pkg::KIND_ERROR;
                                emit_last     = 1'b1;
                            end
                            else
                            begin
                                zero_run_next = zero_run_reg + CB'(1);
                            end
                        end
                        else if (dec_cnt > zero_run_reg)
                        begin
                            // payload complete
                            emit          = 1'b1;
                            emit_kind     = sgc_pkg::KIND_VALUE;
                            emit_val      = dec_val;
                            emit_last     = 1'b1;
                            reading_next  = 1'b0;
                            zero_run_next = '0;
                            pay_next      = '0;
                            pay_cnt_next  = '0;
                        end
                        else
                        begin
                            reading_next = 1'b1;
                            pay_next     = dec_pay;
                            pay_cnt_next = dec_cnt;
                        end
                    end
                    else
                    begin
                        m_next     = m_in;
                        nbits_next = CB'(sgc_pkg::VALUE_BITS);
                        eos_next   = item.end_of_stream;
                        state_next = ST_NORM;
                    end
                end
            end

            ST_NORM:
            begin
                if (m_reg[MB-1])
                begin
                    cnt_next   = nbits_reg;
                    state_next = (nbits_reg == '0) ? ST_BITS : ST_ZEROS;
                end
                else
                begin
                    m_next     = m_reg << 1;
                    nbits_next = nbits_reg - CB'(1);
                end
            end

            ST_ZEROS:
            begin
                if (can_emit)
                begin
                    emit      = 1'b1;
                    emod_next = emod_reg + 3'd1;
                    cnt_next  = cnt_reg - CB'(1);
                    if (cnt_reg == CB'(1))
                    begin
                        cnt_next   = nbits_reg;
                        state_next = ST_BITS;
                    end
                end
            end

            ST_BITS:
            begin
                if (can_emit)
                begin
                    emit      = 1'b1;
                    emit_bit  = m_reg[MB-1];
                    m_next    = m_reg << 1;
                    emod_next = emod_reg + 3'd1;
                    cnt_next  = cnt_reg - CB'(1);
                    if (cnt_reg == '0)
                    begin
                        // pad length is 7 - emod_reg, none when it is zero
                        if (eos_reg && (emod_reg != 3'd7))
                        begin
                            cnt_next   = CB'(3'd7 - emod_reg);
                            state_next = ST_PAD;
                        end
                        else
                        begin
                            emit_last  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                end
            end

            ST_PAD:
            begin
                if (can_emit)
                begin
                    emit      = 1'b1;
                    emod_next = emod_reg + 3'd1;
                    cnt_next  = cnt_reg - CB'(1);
                    if (cnt_reg == CB'(1))
                    begin
                        emit_last  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= 1'b0;
            emod_reg      <= '0;
            zero_run_reg  <= '0;
            reading_reg   <= 1'b0;
            pay_reg       <= '0;
            pay_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            emod_reg     <= emod_next;
            zero_run_reg <= zero_run_next;
            reading_reg  <= reading_next;
            pay_reg      <= pay_next;
            pay_cnt_reg  <= pay_cnt_next;
            if (cfg.valid)
            begin
                mode_reg <= cfg.decode_mode;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath and output payload
    always_ff @(posedge clk)
    begin
        m_reg     <= m_next;
        nbits_reg <= nbits_next;
        cnt_reg   <= cnt_next;
        eos_reg   <= eos_next;
        if (emit)
        begin
            out_kind_reg <= emit_kind;
            out_bit_reg  <= emit_bit;
            out_val_reg  <= emit_val;
            out_last_reg <= emit_last;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.result_kind   = out_kind_reg;
    assign result.out_bit       = out_bit_reg;
    assign result.decoded_value = out_val_reg;
    assign result.last_of_run   = out_last_reg;

`ifndef NO_ASSERTIONS
    // normalization must terminate: the mapped value is never zero
    a_norm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NORM) |-> (m_reg != '0))
        else $error("normalizing a zero mapped value");

    // a partly read payload never already exceeds the prefix length
    a_payload_bound: assert property (@(posedge clk) disable iff (!rst_n)
        reading_reg |-> (pay_cnt_reg <= zero_run_reg))
        else $error("decoder payload longer than its zero prefix");

    // padding ends exactly on a byte boundary
    a_pad_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAD && can_emit && cnt_reg == CB'(1)) |=> (emod_reg == 3'd0))
        else $error("padding does not end on a byte boundary");

    // an encode item is only taken in idle and then starts normalization
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready && !mode_reg) |=> (state_reg == ST_NORM))
        else $error("encode item did not start normalization");
`endif

endmodule

// ----- verif/tb_signed_elias_gamma_codec.sv -----
// self-checking testbench of the signed elias gamma codec
module tb_signed_elias_gamma_codec;

    localparam int VALUE_BITS = sgc_pkg::VALUE_BITS;
    localparam int M_BITS     = sgc_pkg::M_BITS;

    // largest and smallest value that the encoder takes
    localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
    // load, normalize and up to 64 code and pad bits, with margin
    localparam int DRAIN_CYCLES = 100;
    // one long receiver hold that backs the encoder up into its input
    localparam int LONG_HOLD    = 250;
    // cycles with no handshake at all before the run is given up
    localparam int STALL_LIMIT  = 3000;
    // random encode items offered during the long hold
    localparam int ENCODE_ITEMS = 6;
    // short random codes are sent until this many items went in
    localparam int SHORT_ITEMS  = 28;

    // one result of the codec, laid out like the result channel
    typedef struct packed {
        sgc_pkg::kind_t    result_kind;
        logic              out_bit;
        logic [M_BITS-1:0] decoded_value;
        logic              last_of_run;
    } codec_out_t;

    // keeps its own copy of the coder state and the queue of results still owed
    class codec_scoreboard;
        logic              decode_mode;
        logic [5:0]        zero_run;
        logic              reading_payload;
        logic [M_BITS-1:0] payload_bits;
        logic [5:0]        payload_count;
        logic [2:0]        emitted_mod_eight;
        codec_out_t        outputs_due[$];
        int                mismatches;

        function new();
            decode_mode       = 1'b0;
            zero_run          = '0;
            reading_payload   = 1'b0;
            payload_bits      = '0;
            payload_count     = '0;
            emitted_mod_eight = '0;
            mismatches        = 0;
        endfunction

        // zero to 1, positive v to 2v+1, negative v to -2v
        static function logic [M_BITS-1:0] fold_sign(logic [VALUE_BITS-1:0] raw);
            logic [M_BITS-1:0] magnitude;
            if (raw == '0)
                return M_BITS'(1);
            if (!raw[VALUE_BITS-1])
                return {raw, 1'b1};
            magnitude = (M_BITS'(1) << VALUE_BITS) - M_BITS'(raw);
            return magnitude << 1;
        endfunction

        // floor(log2 m), the number of leading zero bits of the code
        static function int top_bit(logic [M_BITS-1:0] m);
            int msb;
            msb = 0;
            for (int i = 0; i < M_BITS; i++)
                if (m[i])
                    msb = i;
            return msb;
        endfunction

        function void owe(sgc_pkg::kind_t kind, logic b, logic [M_BITS-1:0] v);
            codec_out_t r;
            r.result_kind   = kind;
            r.out_bit       = b;
            r.decoded_value = v;
            r.last_of_run   = 1'b0;
            outputs_due     = {outputs_due, r};
        endfunction

        function void encode_value(logic [VALUE_BITS-1:0] raw, logic eos);
            logic [M_BITS-1:0] mapped;
            int                zeros;
            logic [2:0]        pad;
            mapped = fold_sign(raw);
            zeros  = top_bit(mapped);
            repeat (zeros)
                owe(sgc_pkg::KIND_BIT, 1'b0, '0);
            for (int i = zeros; i >= 0; i--)
                owe(sgc_pkg::KIND_BIT, mapped[i], '0);
            emitted_mod_eight = emitted_mod_eight + 3'(2 * zeros + 1);
            if (eos)
            begin
                pad = 3'd0 - emitted_mod_eight;
                repeat (pad)
                    owe(sgc_pkg::KIND_BIT, 1'b0, '0);
                emitted_mod_eight = '0;
            end
        endfunction

        function void decode_bit(logic b);
            logic [M_BITS-1:0] n;
            if (!reading_payload)
            begin
                if (!b)
                begin
                    if (zero_run >= VALUE_BITS)
                    begin
                        zero_run = '0;
                        owe(sgc_pkg::KIND_ERROR, 1'b0, '0);
                    end
                    else
                        zero_run++;
                    return;
                end
                payload_bits    = M_BITS'(1);
                payload_count   = 6'd1;
                reading_payload = 1'b1;
            end
            else
            begin
                payload_bits  = {payload_bits[M_BITS-2:0], b};
                payload_count = payload_count + 6'd1;
            end
            if (payload_count <= zero_run)
                return;
            n               = payload_bits;
            reading_payload = 1'b0;
            zero_run        = '0;
            payload_bits    = '0;
            payload_count   = '0;
            if (n == M_BITS'(1))
                owe(sgc_pkg::KIND_VALUE, 1'b0, '0);
            else if (!n[0])
                owe(sgc_pkg::KIND_VALUE, 1'b0, -(n >> 1));
            else
                owe(sgc_pkg::KIND_VALUE, 1'b0, (n - M_BITS'(1)) >> 1);
        endfunction

        // an item was accepted: queue what it must cause
        function void absorb_item(logic [VALUE_BITS-1:0] value, logic cbit, logic eos);
            int queued;
            queued = outputs_due.size();
            if (decode_mode)
                decode_bit(cbit);
            else
                encode_value(value, eos);
            if (outputs_due.size() > queued)
                outputs_due[outputs_due.size()-1].last_of_run = 1'b1;
        endfunction

        // a result was accepted: compare it with the oldest one owed
        function void check_output(codec_out_t got);
            codec_out_t want;
            if (outputs_due.size() == 0)
            begin
                $error("result with nothing owed: result_kind %0d out_bit %0d", got.result_kind,
                       got.out_bit);
                mismatches++;
                return;
            end
            want = outputs_due.pop_front();
            if (got.result_kind !== want.result_kind)
            begin
                $error("result_kind: expected %0d, actual %0d", want.result_kind, got.result_kind);
                mismatches++;
            end
            if (got.out_bit !== want.out_bit)
            begin
                $error("out_bit: expected %0d, actual %0d", want.out_bit, got.out_bit);
                mismatches++;
            end
            if (got.decoded_value !== want.decoded_value)
            begin
                $error("decoded_value: expected %0d, actual %0d", $signed(want.decoded_value),
                       $signed(got.decoded_value));
                mismatches++;
            end
            if (got.last_of_run !== want.last_of_run)
            begin
                $error("last_of_run: expected %0d, actual %0d", want.last_of_run, got.last_of_run);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    // set by the stimulus, cleared by the result sink once the long hold is over
    logic choke_sink = 1'b0;
    // input items accepted so far
    int   items_sent = 0;

    codec_scoreboard board;

    sgc_item_if   item_ch();
    sgc_result_if result_ch();
    sgc_cfg_if    cfg_ch();

    signed_elias_gamma_codec uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // idle length: mostly a few cycles, now and then a long one
    function automatic int gap_length();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(6, 30);
    endfunction

    // random value, shifted right arithmetically to spread the code lengths
    function automatic logic [VALUE_BITS-1:0] random_value(input int min_shift);
        logic signed [VALUE_BITS-1:0] v;
        v = VALUE_BITS'($urandom());
        return v >>> $urandom_range(min_shift, VALUE_BITS - 1);
    endfunction

    // offer one item and return at the falling edge after it was taken
    task automatic offer_item(input logic signed [VALUE_BITS-1:0] value, input logic cbit,
                              input logic eos);
        int gap;
        // no gaps while the receiver is held off, so the block backs up
        gap = (!choke_sink && $urandom_range(0, 2) == 0) ? gap_length() : 0;
        if (gap > 0)
        begin
            item_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid         = 1'b1;
        item_ch.signed_value  = value;
        item_ch.code_bit      = cbit;
        item_ch.end_of_stream = eos;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        items_sent++;
        @(negedge clk);
    endtask

    // decode item: value and end of stream are ignored there, so fill them with noise
    task automatic offer_bit(input logic b);
        offer_item(VALUE_BITS'($urandom()), b, 1'(($urandom_range(0, 1))));
    endtask

    // well-formed gamma code of one value, one bit per item
    task automatic send_code(input logic [VALUE_BITS-1:0] value);
        logic [M_BITS-1:0] mapped;
        int                zeros;
        mapped = codec_scoreboard::fold_sign(value);
        zeros  = codec_scoreboard::top_bit(mapped);
        repeat (zeros)
            offer_bit(1'b0);
        for (int i = zeros; i >= 0; i--)
            offer_bit(mapped[i]);
    endtask

    // wait until every owed result is in, then let the block run dry
    task automatic settle();
        item_ch.valid = 1'b0;
        while (board.outputs_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // mode register, written only with the block idle
    task automatic write_mode(input logic m);
        settle();
        cfg_ch.valid       = 1'b1;
        cfg_ch.decode_mode = m;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        board.decode_mode = m;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // random values while the receiver is held off, so the block backs up
    task automatic encode_phase();
        choke_sink = 1'b1;
        repeat (ENCODE_ITEMS)
            offer_item(random_value($urandom_range(0, 1) ? 0 : 20), 1'($urandom_range(0, 1)),
                       $urandom_range(0, 3) == 0);
    endtask

    // short random codes, then the overlong zero run and the widest code
    task automatic decode_phase();
        while (items_sent < SHORT_ITEMS)
            send_code(random_value(22));
        // zero run one past the limit: error result
        repeat (VALUE_BITS + 1) offer_bit(1'b0);
        // longest zero run with a full random payload: decoded value beyond the encode range
        repeat (VALUE_BITS) offer_bit(1'b0);
        offer_bit(1'b1);
        repeat (VALUE_BITS) offer_bit(1'($urandom_range(0, 1)));
    endtask

    // result sink: random stalls, calm stretches, and the one long hold on request
    initial
    begin : result_sink
        int stall_left;
        int calm_left;
        stall_left      = 0;
        calm_left       = 0;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (choke_sink)
            begin
                result_ch.ready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                choke_sink = 1'b0;
            end
            else if (stall_left > 0)
            begin
                result_ch.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                result_ch.ready = 1'b1;
                if (calm_left > 0)
                    calm_left--;
                else if ($urandom_range(0, 3) == 0)
                    stall_left = gap_length();
                else if ($urandom_range(0, 9) == 0)
                    calm_left = $urandom_range(20, 80);
            end
        end
    end

    // both handshakes seen at the rising edge; the item is predicted before any result is checked
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (item_ch.valid === 1'b1 && item_ch.ready === 1'b1)
                board.absorb_item(item_ch.signed_value, item_ch.code_bit,
                                  item_ch.end_of_stream);
            if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
                board.check_output('{result_ch.result_kind, result_ch.out_bit,
                                     result_ch.decoded_value, result_ch.last_of_run});
        end
    end

    // watchdog: too long without any handshake ends the run
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
                (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) ||
                (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_signed_elias_gamma_codec: errors");
        $finish;
    end

    initial
    begin : stimulus
        board                 = new();
        rst_n                 = 1'b0;
        item_ch.valid         = 1'b0;
        item_ch.signed_value  = '0;
        item_ch.code_bit      = 1'b0;
        item_ch.end_of_stream = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.decode_mode    = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // encoder: zero, unit values, both extremes, padding
        write_mode(1'b0);
        offer_item(VALUE_BITS'(0), 1'b1, 1'b0);
        offer_item(VALUE_BITS'(1), 1'b0, 1'b0);
        offer_item(VALUE_BITS'(-1), 1'b1, 1'b0);
        offer_item(VALUE_BITS'(2), 1'b0, 1'b1);
        offer_item(VALUE_BITS'(-2), 1'b1, 1'b0);
        offer_item(VALUE_MAX, 1'b0, 1'b0);
        offer_item(VALUE_MIN, 1'b1, 1'b1);
        // seven plus one bits: end of stream already on a byte boundary, no pad
        offer_item(VALUE_BITS'(7), 1'b0, 1'b0);
        offer_item(VALUE_BITS'(0), 1'b1, 1'b1);
        // leave a partial byte behind across the mode change
        offer_item(VALUE_BITS'(3), 1'b0, 1'b0);

        // decoder: short codes, then a code cut off by a mode change
        write_mode(1'b1);
        send_code(VALUE_BITS'(0));
        send_code(VALUE_BITS'(-1));
        offer_bit(1'b0);
        offer_bit(1'b0);
        offer_bit(1'b1);

        // encoder state carried over, decoder state left pending
        write_mode(1'b0);
        offer_item(VALUE_BITS'(-3), 1'b1, 1'b1);
        offer_item(VALUE_BITS'(6), 1'b0, 1'b0);

        // finish the pending code: value 2
        write_mode(1'b1);
        offer_bit(1'b0);
        offer_bit(1'b1);

        // random part; the encode phase backs the block up
        write_mode(1'b0);
        encode_phase();
        write_mode(1'b1);
        decode_phase();

        settle();
        if (board.mismatches == 0)
            $display("tb_signed_elias_gamma_codec: clean");
        else
            $display("tb_signed_elias_gamma_codec: errors");
        $finish;
    end

endmodule
